// File: rtl/core/spa_pkg.sv
// Shared types and codes for the slot pool allocator.
// Request and response payload structs, opcode and status codes.
// No dependencies.
`default_nettype none

package spa_pkg;

  localparam int unsigned IdxW = 8;
  localparam int unsigned CntW = 9;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_NOT_LIVE = 2'd2;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [IdxW-1:0] slot_index;
  } spa_req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdxW-1:0] granted_index;
    logic            slot_live;
    logic [CntW-1:0] live_total;
    logic [CntW-1:0] high_water;
  } spa_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/spa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Parameters set word width and depth. No dependencies.
`default_nettype none

module spa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/slot_pool_allocator.sv
// Slot pool allocator top level: LIFO free stack plus occupancy store.
// Depends on spa_pkg and spa_ram.
//
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_data_i) carries an opcode
//   (acquire, release, query) and a slot index. Response channel
//   (out_valid_o / out_stall_i / out_data_o) returns one transaction per
//   request: status, granted index, live flag, live and high-water counts.
//   cfg_we_i / cfg_wdata_i write the slot limit (reset value 256); write
//   only while no request is in flight.
// Timing:
//   The stack entry and occupancy bit are read from the two RAMs at the
//   accepting edge; the read-modify-write plus response load happen when
//   the EXEC state fires, once the response register is free. The read
//   port is registered ahead of the write-back, so a new request is taken
//   only after the current one has been written back.
//   While the response register is full and stalled, the block holds the
//   request in flight; it takes a new one once the response slot frees.
// Reset:
//   Counters and free stack pointer clear at once. Neither RAM needs a
//   clearing pass: occupancy bits are only looked at below the high-water
//   mark, and every slot below it has been written on its first grant.
`default_nettype none

module slot_pool_allocator
  import spa_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire spa_req_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output spa_rsp_t      out_data_o,
  input  wire logic     cfg_we_i,
  input  wire logic [CntW-1:0] cfg_wdata_i
);

  localparam int unsigned Cap = (SLOTS < 256) ? SLOTS : 256;
  localparam int unsigned AW  = $clog2(Cap);
  localparam logic [CntW-1:0] CapCnt = CntW'(Cap);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e          state_q, state_d;
  spa_req_t        req_q, req_d;
  logic [CntW-1:0] free_top_q, free_top_d;
  logic [CntW-1:0] hw_q, hw_d;
  logic [CntW-1:0] live_q, live_d;
  logic [CntW-1:0] limit_q, limit_d;
  logic            out_valid_q, out_valid_d;
  spa_rsp_t        out_q, out_d;

  logic            accept;
  logic            exec_fire;
  logic [CntW-1:0] top_dec;
  logic [CntW-1:0] eff_limit;
  logic [CntW-1:0] idx_cnt;
  logic [CntW-1:0] pop_cnt;
  logic            is_live;

  logic            stk_we;
  logic [AW-1:0]   stk_waddr;
  logic [IdxW-1:0] stk_rdata;
  logic            occ_we;
  logic [AW-1:0]   occ_waddr;
  logic            occ_wdata;
  logic            occ_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign exec_fire  = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  assign top_dec   = free_top_q - CntW'(1);
  assign eff_limit = (limit_q > CapCnt) ? CapCnt : limit_q;
  assign idx_cnt   = {1'b0, req_q.slot_index};
  assign pop_cnt   = {1'b0, stk_rdata};
  assign is_live   = (idx_cnt < hw_q) && (idx_cnt < CapCnt) && occ_rdata;

  spa_ram #(
    .WIDTH(IdxW),
    .DEPTH(Cap)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(req_q.slot_index),
    .re_i   (accept),
    .raddr_i(top_dec[AW-1:0]),
    .rdata_o(stk_rdata)
  );

  spa_ram #(
    .WIDTH(1),
    .DEPTH(Cap)
  ) u_occ_ram (
    .clk_i  (clk_i),
    .we_i   (occ_we),
    .waddr_i(occ_waddr),
    .wdata_i(occ_wdata),
    .re_i   (accept),
    .raddr_i(in_data_i.slot_index[AW-1:0]),
    .rdata_o(occ_rdata)
  );

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    free_top_d  = free_top_q;
    hw_d        = hw_q;
    live_d      = live_q;
    limit_d     = cfg_we_i ? cfg_wdata_i : limit_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    stk_we      = 1'b0;
    stk_waddr   = free_top_q[AW-1:0];
    occ_we      = 1'b0;
    occ_waddr   = req_q.slot_index[AW-1:0];
    occ_wdata   = 1'b0;

    if (accept) begin
      req_d   = in_data_i;
      state_d = ST_EXEC;
    end

    if (exec_fire) begin
      out_d.status        = STS_NOT_LIVE;
      out_d.granted_index = '0;
      out_d.slot_live     = 1'b0;
      case (req_q.opcode)
        OP_ACQUIRE: begin
          if (free_top_q != '0) begin
            free_top_d = top_dec;
            if (pop_cnt < CapCnt) begin
              occ_we              = 1'b1;
              occ_waddr           = stk_rdata[AW-1:0];
              occ_wdata           = 1'b1;
              live_d              = live_q + CntW'(1);
              out_d.granted_index = stk_rdata;
              out_d.status        = STS_OK;
            end
          end else if (hw_q < eff_limit) begin
            hw_d                = hw_q + CntW'(1);
            occ_we              = 1'b1;
            occ_waddr           = hw_q[AW-1:0];
            occ_wdata           = 1'b1;
            live_d              = live_q + CntW'(1);
            out_d.granted_index = hw_q[IdxW-1:0];
            out_d.status        = STS_OK;
          end else begin
            out_d.status = STS_FULL;
          end
        end
        OP_RELEASE: begin
          if (is_live && (live_q != '0) && (free_top_q < CapCnt)) begin
            stk_we       = 1'b1;
            free_top_d   = free_top_q + CntW'(1);
            occ_we       = 1'b1;
            live_d       = live_q - CntW'(1);
            out_d.status = STS_OK;
          end
        end
        OP_QUERY: begin
          if (is_live) begin
            out_d.slot_live = 1'b1;
            out_d.status    = STS_OK;
          end
        end
        default: begin
        end
      endcase
      out_d.live_total = live_d;
      out_d.high_water = hw_d;
      out_valid_d      = 1'b1;
      state_d          = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      free_top_q  <= '0;
      hw_q        <= '0;
      live_q      <= '0;
      limit_q     <= CntW'(256);
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      free_top_q  <= free_top_d;
      hw_q        <= hw_d;
      live_q      <= live_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking bench for slot_pool_allocator: directed and random acquire, release and query
// traffic under several slot limits, with idle and stall bursts on both channels.
// Depends on spa_pkg and the slot_pool_allocator RTL.
`timescale 1ns / 1ps

module tb_top;
  import spa_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned IDX_CAP = 256;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS = 275;

  // Tracks allocator state and queues the response each accepted request should produce.
  class slot_pool_scoreboard;
    logic [IdxW-1:0] free_stack [IDX_CAP];
    bit              occupied [IDX_CAP];
    int unsigned     free_top;
    int unsigned     high_water;
    int unsigned     live_slots;
    int unsigned     slot_limit;
    int unsigned     errors;
    spa_rsp_t        expected_q [$];

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      free_top   = 0;
      high_water = 0;
      live_slots = 0;
      slot_limit = 256;
      errors     = 0;
    endfunction

    function bit slot_is_live(int unsigned idx);
      return idx < high_water && occupied[idx];
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(spa_req_t req);
      spa_rsp_t    rsp;
      int unsigned cap;
      int unsigned grant;
      rsp        = '0;
      rsp.status = STS_NOT_LIVE;
      cap        = (slot_limit > IDX_CAP) ? IDX_CAP : slot_limit;
      case (req.opcode)
        OP_ACQUIRE: begin
          if (free_top > 0) begin
            free_top--;
            grant = free_stack[free_top];
          end else if (high_water < cap) begin
            grant = high_water;
            high_water++;
          end else begin
            grant = IDX_CAP;
            rsp.status = STS_FULL;
          end
          if (grant < IDX_CAP) begin
            occupied[grant] = 1'b1;
            live_slots++;
            rsp.granted_index = grant[IdxW-1:0];
            rsp.status = STS_OK;
          end
        end
        OP_RELEASE: begin
          if (slot_is_live(req.slot_index) && live_slots > 0 && free_top < IDX_CAP) begin
            free_stack[free_top] = req.slot_index;
            free_top++;
            occupied[req.slot_index] = 1'b0;
            live_slots--;
            rsp.status = STS_OK;
          end
        end
        OP_QUERY: begin
          if (slot_is_live(req.slot_index)) begin
            rsp.slot_live = 1'b1;
            rsp.status = STS_OK;
          end
        end
        default: ;
      endcase
      rsp.live_total = live_slots[CntW-1:0];
      rsp.high_water = high_water[CntW-1:0];
      expected_q.push_back(rsp);
    endfunction

    function void check_response(spa_rsp_t got);
      spa_rsp_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result error: unexpected transaction st=%0d gi=%0d lv=%0b lt=%0d hw=%0d",
                   got.status, got.granted_index, got.slot_live, got.live_total, got.high_water);
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status || got.granted_index !== exp.granted_index ||
          got.slot_live !== exp.slot_live || got.live_total !== exp.live_total ||
          got.high_water !== exp.high_water) begin
        errors++;
        if (errors <= 10)
          $display("result error at %0t: exp %0d/%0d/%0b/%0d/%0d got %0d/%0d/%0b/%0d/%0d",
                   $time, exp.status, exp.granted_index, exp.slot_live, exp.live_total,
                   exp.high_water, got.status, got.granted_index, got.slot_live,
                   got.live_total, got.high_water);
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  spa_req_t        in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  spa_rsp_t        out_data_o;
  logic            cfg_we_i = 1'b0;
  logic [CntW-1:0] cfg_wdata_i = '0;

  slot_pool_scoreboard sb = new();

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          quiet = 1'b0;
  int unsigned stall_left = 0;
  int unsigned watchdog = 0;

  slot_pool_allocator #(.SLOTS(256)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Response monitor plus stall burst generator; a new burst never starts while the stall is still raised.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_response(out_data_o);
    if (!rst_ni || quiet) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!out_stall_i && $urandom_range(99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(17, 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      watchdog <= 0;
    end else if (watchdog >= WATCHDOG_LIMIT) begin
      $display("slot_pool_allocator: mismatch");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  task automatic issue(input logic [1:0] op, input logic [IdxW-1:0] idx);
    spa_req_t req;
    req.opcode     = op;
    req.slot_index = idx;
    if (!quiet && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req);
  endtask

  // Let the block go idle before touching the limit register.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CntW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.slot_limit = value;
  endtask

  function automatic logic [IdxW-1:0] pick_live_slot();
    int unsigned start;
    start = $urandom_range(IDX_CAP - 1);
    for (int unsigned i = 0; i < IDX_CAP; i++)
      if (sb.slot_is_live((start + i) % IDX_CAP)) return IdxW'((start + i) % IDX_CAP);
    return IdxW'(start);
  endfunction

  function automatic spa_req_t random_request(int unsigned acq_pct);
    spa_req_t    req;
    int unsigned roll;
    int unsigned rel_end;
    roll    = $urandom_range(99);
    rel_end = acq_pct + (97 - acq_pct) * 2 / 3;
    req.slot_index = IdxW'($urandom_range(IDX_CAP - 1));
    if (roll < acq_pct) req.opcode = OP_ACQUIRE;
    else if (roll < rel_end) req.opcode = OP_RELEASE;
    else if (roll < 97) req.opcode = OP_QUERY;
    else req.opcode = OP_UNUSED;
    // Mostly aim releases and queries at live slots so the free stack sees real traffic.
    if ((req.opcode == OP_RELEASE || req.opcode == OP_QUERY) && sb.live_slots > 0 &&
        $urandom_range(9) < 8)
      req.slot_index = pick_live_slot();
    return req;
  endfunction

  task automatic run_phase(input logic [CntW-1:0] limit_val, input int unsigned acq_pct,
                           input int unsigned gap_pct);
    spa_req_t req;
    drain();
    write_limit(limit_val);
    idle_pct  = gap_pct;
    stall_pct = gap_pct;
    repeat (PHASE_ITEMS) begin
      req = random_request(acq_pct);
      issue(req.opcode, req.slot_index);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_limit(9'd256);
    idle_pct  = 30;
    stall_pct = 30;
    issue(OP_QUERY, 8'd0);       // nothing live yet
    issue(OP_RELEASE, 8'd0);     // live count zero
    issue(OP_UNUSED, 8'd255);
    issue(OP_ACQUIRE, 8'd255);
    issue(OP_ACQUIRE, 8'd0);
    issue(OP_ACQUIRE, 8'd170);
    issue(OP_QUERY, 8'd1);
    issue(OP_QUERY, 8'd255);     // above high water
    issue(OP_RELEASE, 8'd1);
    issue(OP_RELEASE, 8'd1);     // already free
    issue(OP_QUERY, 8'd1);
    issue(OP_ACQUIRE, 8'd85);    // pops slot 1
    issue(OP_RELEASE, 8'd2);
    issue(OP_RELEASE, 8'd0);
    issue(OP_ACQUIRE, 8'd0);     // LIFO order: 0 then 2
    issue(OP_ACQUIRE, 8'd0);
    issue(OP_ACQUIRE, 8'd0);     // fresh slot 3
    issue(OP_RELEASE, 8'd200);   // above high water

    // limit lowered below high water: freed slots still pop, fresh ones are refused
    drain();
    write_limit(9'd2);
    issue(OP_RELEASE, 8'd3);
    issue(OP_ACQUIRE, 8'd0);
    issue(OP_ACQUIRE, 8'd0);
    issue(OP_UNUSED, 8'd0);

    drain();
    write_limit(9'd0);
    issue(OP_ACQUIRE, 8'd0);

    run_phase(9'd511, 55, 25);   // saturates to full capacity
    run_phase(9'd1, 40, 0);
    run_phase(9'd300, 80, 10);   // drives the pool to full
    run_phase(9'd256, 45, 40);
    run_phase(CntW'($urandom_range(511, 1)), 50, 20);
    run_phase(9'd0, 50, 15);
    drain();
    quiet = 1'b1;
    run_phase(9'd256, 50, 0);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("slot_pool_allocator: match");
    end else begin
      $display("slot_pool_allocator: mismatch");
    end
    $finish;
  end

endmodule

// File: slot_pool_allocator.f
rtl/core/spa_pkg.sv
rtl/core/spa_ram.sv
rtl/core/slot_pool_allocator.sv
sim/tb_top.sv
